// File: rtl/core/ccrr_pkg.sv
// Shared types, constants and the CRC-8 step for the checked record reader.
// No dependencies; every other file of the block refers to it by scoped names.
package ccrr_pkg;

   // Field widths fixed by the record format.
   localparam int ADDR_W     = 10;
   localparam int CUR_ADDR_W = 11;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int SUM_W      = 13;

   // Store geometry and record wrapper (marker, length and CRC bytes).
   localparam int STORE_LAST_ADDRESS = 1023;
   localparam int WRAPPER_BYTES      = 3;

   // CRC-8 generator polynomial, MSB first.
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'hD8;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Status codes of the final result.
   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_END_EXCEEDED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_START    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_LENGTH   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CRC_MISMATCH = 3'd4;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LENGTH = 1'b1;

   // Configuration reset values.
   localparam logic [BYTE_W-1:0] START_MARKER_RESET  = 8'h00;
   localparam logic [BYTE_W-1:0] BUFFER_LENGTH_RESET = 8'hFF;

   // One store byte as it arrives on the request channel.
   typedef struct packed {
      logic              begin_req;
      logic [ADDR_W-1:0] record_address;
      logic [BYTE_W-1:0] byte_value;
   } req_type;

   // One result item.
   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   next_address;
      logic                last;
   } rsp_type;

   // A result produced by the parser, with its valid flag.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // Folds one byte into the CRC remainder: eight shift steps, unrolled.
   function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] rem,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      r = rem ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[BYTE_W-1]) begin
            r = (r << 1) ^ CRC_POLY;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/core/ccrr_parse.sv
// Record parser: phase, byte count, CRC remainder and address registers,
// with the per-byte checks. Depends on ccrr_pkg.
module ccrr_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  ccrr_pkg::req_type            req,
   input  logic [ccrr_pkg::BYTE_W-1:0]  start_marker,
   input  logic [ccrr_pkg::BYTE_W-1:0]  buffer_length,
   output ccrr_pkg::result_type         result
);

   // Parser phases.
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_CRC     = 2'd3;

   localparam logic [ccrr_pkg::SUM_W-1:0] LAST_ADDR =
      ccrr_pkg::SUM_W'(ccrr_pkg::STORE_LAST_ADDRESS);
   localparam logic [ccrr_pkg::SUM_W-1:0] WRAP =
      ccrr_pkg::SUM_W'(ccrr_pkg::WRAPPER_BYTES);

   logic [1:0]                        phase_ff, phase_in;
   logic [ccrr_pkg::BYTE_W-1:0]       left_ff, left_in;
   logic [ccrr_pkg::BYTE_W-1:0]       crc_ff, crc_in;
   logic [ccrr_pkg::CUR_ADDR_W-1:0]   cur_ff, cur_in;

   logic [ccrr_pkg::CUR_ADDR_W-1:0]   cur_next;
   logic [ccrr_pkg::BYTE_W-1:0]       left_dec;
   logic [ccrr_pkg::SUM_W-1:0]        begin_end;
   logic [ccrr_pkg::SUM_W-1:0]        record_end;

   // Address sums for the two room checks.
   assign cur_next   = cur_ff + 1'b1;
   assign left_dec   = left_ff - 1'b1;
   assign begin_end  = ccrr_pkg::SUM_W'(req.record_address) + WRAP;
   assign record_end = ccrr_pkg::SUM_W'(cur_next) + ccrr_pkg::SUM_W'(req.byte_value) + WRAP;

   // Next state and result for the byte being transferred.
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      crc_in   = crc_ff;
      cur_in   = cur_ff;
      result   = '0;
      if (accept) begin
         if (req.begin_req) begin
            // A begin restarts parsing, dropping any record in progress.
            cur_in  = ccrr_pkg::CUR_ADDR_W'(req.record_address);
            crc_in  = '0;
            left_in = '0;
            if (begin_end > LAST_ADDR) begin
               phase_in                  = PH_IDLE;
               result.valid              = 1'b1;
               result.data.kind          = ccrr_pkg::KIND_STATUS;
               result.data.status        = ccrr_pkg::ST_END_EXCEEDED;
               result.data.last          = 1'b1;
            end else if (req.byte_value != start_marker) begin
               phase_in                  = PH_IDLE;
               result.valid              = 1'b1;
               result.data.kind          = ccrr_pkg::KIND_STATUS;
               result.data.status        = ccrr_pkg::ST_BAD_START;
               result.data.last          = 1'b1;
            end else begin
               cur_in   = ccrr_pkg::CUR_ADDR_W'(req.record_address) + 1'b1;
               phase_in = PH_LENGTH;
            end
         end else begin
            case (phase_ff)
               PH_LENGTH: begin
                  cur_in = cur_next;
                  if (req.byte_value > buffer_length) begin
                     phase_in           = PH_IDLE;
                     left_in            = '0;
                     result.valid       = 1'b1;
                     result.data.kind   = ccrr_pkg::KIND_STATUS;
                     result.data.status = ccrr_pkg::ST_BAD_LENGTH;
                     result.data.last   = 1'b1;
                  end else if (record_end > LAST_ADDR) begin
                     phase_in           = PH_IDLE;
                     left_in            = '0;
                     result.valid       = 1'b1;
                     result.data.kind   = ccrr_pkg::KIND_STATUS;
                     result.data.status = ccrr_pkg::ST_END_EXCEEDED;
                     result.data.last   = 1'b1;
                  end else begin
                     crc_in   = '0;
                     left_in  = req.byte_value;
                     phase_in = (req.byte_value == '0) ? PH_CRC : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  crc_in  = ccrr_pkg::crc_byte(crc_ff, req.byte_value);
                  cur_in  = cur_next;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = PH_CRC;
                  end
                  result.valid             = 1'b1;
                  result.data.kind         = ccrr_pkg::KIND_PAYLOAD;
                  result.data.payload_byte = req.byte_value;
               end
               PH_CRC: begin
                  cur_in             = cur_next;
                  phase_in           = PH_IDLE;
                  left_in            = '0;
                  result.valid       = 1'b1;
                  result.data.kind   = ccrr_pkg::KIND_STATUS;
                  result.data.last   = 1'b1;
                  if (req.byte_value != crc_ff) begin
                     result.data.status = ccrr_pkg::ST_CRC_MISMATCH;
                  end else begin
                     result.data.status       = ccrr_pkg::ST_OK;
                     result.data.next_address = cur_next[ccrr_pkg::ADDR_W-1:0];
                  end
               end
               default: begin
                  // Bytes outside a record are dropped.
               end
            endcase
         end
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         crc_ff   <= '0;
         cur_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         crc_ff   <= crc_in;
         cur_ff   <= cur_in;
      end
   end

endmodule

// File: rtl/core/ccrr_skid.sv
// Result register with a skid stage, so a byte can be taken while a result waits.
// Depends on ccrr_pkg.
module ccrr_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  ccrr_pkg::result_type  result,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ccrr_pkg::rsp_type     rsp_payload
);

   logic              out_valid_ff, out_valid_in;
   ccrr_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   ccrr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_take;

   assign out_take    = out_valid_ff & ~rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // Refill the output from the skid stage first, then from the parser.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result.data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.data;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid flags are reset; data registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: rtl/core/crc_checked_record_reader.sv
// Top level of the CRC-8 checked record reader: configuration registers,
// parser and output stage. Depends on ccrr_pkg, ccrr_parse and ccrr_skid.
//
//   Channel  Direction  Handshake              Transfer
//   req_     in         req_valid / req_stall  one store byte with begin flag and address
//   rsp_     out        rsp_valid / rsp_stall  one payload byte or one final status
//   csr_     in         csr_write_enable       one register write, no read-back
//
// Each byte is checked in the cycle it is transferred; its result goes to the output
// register, or to the skid stage behind it while a result is stalled, which lets one
// more byte in. A byte can be transferred every cycle while req_stall is low; req_stall
// rises only when both stages hold results. Reset is synchronous, clears parser state
// and valid flags and loads the configuration reset values; data registers are not reset.
module crc_checked_record_reader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ccrr_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ccrr_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [ccrr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccrr_pkg::BYTE_W-1:0]         csr_write_data
);

   logic [ccrr_pkg::BYTE_W-1:0] start_marker_ff;
   logic [ccrr_pkg::BYTE_W-1:0] buffer_length_ff;
   logic                        req_accept;
   ccrr_pkg::result_type        result;
   logic                        skid_full;

   assign req_stall  = skid_full;
   assign req_accept = req_valid & ~skid_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= ccrr_pkg::START_MARKER_RESET;
         buffer_length_ff <= ccrr_pkg::BUFFER_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ccrr_pkg::CSR_START_MARKER:  start_marker_ff  <= csr_write_data;
            ccrr_pkg::CSR_BUFFER_LENGTH: buffer_length_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   ccrr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .req           (req_payload),
      .start_marker  (start_marker_ff),
      .buffer_length (buffer_length_ff),
      .result        (result)
   );

   ccrr_skid u_skid (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .full        (skid_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // The skid stage fills only behind a held output result.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("skid stage holds a result while the output register is empty");

   // Status results end a record; payload results do not.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last == rsp_payload.kind))
      else $error("last flag disagrees with result kind");

   // A next address is only reported on a successful record.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ccrr_pkg::ST_OK) |->
      (rsp_payload.next_address == '0))
      else $error("next address reported on a failed record");

   // Payload results carry no status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == ccrr_pkg::KIND_PAYLOAD) |->
      (rsp_payload.status == ccrr_pkg::ST_OK))
      else $error("payload result carries a status code");

endmodule
